@@ design/mfr_pkg.sv @@
// Package for the multidrop frame receiver: byte constants, status codes,
// receive phase encoding and the result item type. No dependencies.
`timescale 1ns / 1ps

package mfr_pkg;

    localparam logic [7:0] PREAMBLE_BYTE  = 8'hAA;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;

    // Frame status codes.
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_NOT_OURS  = 3'd1;
    localparam logic [2:0] ST_BAD_HDR   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_CHECK_ERR = 3'd4;

    // Result kinds carried on tuser.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [6:0] {
        PH_PREAMBLE = 7'b0000001,
        PH_DEST     = 7'b0000010,
        PH_SOURCE   = 7'b0000100,
        PH_LENGTH   = 7'b0001000,
        PH_PAYLOAD  = 7'b0010000,
        PH_CHECK    = 7'b0100000,
        PH_BADPRE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] length;
        logic [7:0] source;
        logic [7:0] dest;
        logic [2:0] status;
        logic [7:0] payload;
        logic       kind;
    } t_result;

endpackage

@@ design/multidrop_frame_receiver.sv @@
// Multidrop frame receiver: parses preamble, header, payload and XOR check
// byte from a byte stream. Depends on mfr_pkg.
`timescale 1ns / 1ps

// A result item is registered when the input item that causes it is
// accepted. Throughput: one input item per cycle while the skid register
// is free; a two-entry output stage (result register plus skid register)
// lets input items keep flowing while a result waits to be taken.
// Reset (synchronous, active low) returns the parser to waiting for a
// preamble, empties the output stage and sets my_address to zero.
module multidrop_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: node address.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [mfr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic        s_axis_tlast,                        // end_of_burst
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [10:8] frame_status, [18:11] dest_address,
    // [26:19] source_address, [34:27] payload_length, [39:35] zero
    output logic [mfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tuser                         // result_kind
);
    import mfr_pkg::*;

    // Parser state.
    t_phase     r_phase, n_phase;
    logic [7:0] r_dest, n_dest;
    logic [7:0] r_source, n_source;
    logic [7:0] r_length, n_length;
    logic [7:0] r_left, n_left;
    logic [7:0] r_check, n_check;
    logic       r_status_sent, n_status_sent;
    logic [7:0] r_my_addr;

    // Output stage: result register and skid register.
    logic       r_out_valid, r_skid_valid;
    t_result    r_out, r_skid;

    logic       in_accept, out_pop;
    logic       has_result;
    t_result    new_result;
    logic [7:0] rx_byte;
    logic       last;

    assign rx_byte   = s_axis_tdata[7:0];
    assign last      = s_axis_tlast;
    assign o_cfg_ready   = 1'b1;
    // Input is taken as long as the skid register is free, so a stalled
    // result never blocks the parser until a second result is pending.
    assign s_axis_tready = ~r_skid_valid;
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign out_pop       = r_out_valid & m_axis_tready;

    // Next parser state and the result caused by the current byte. Status
    // items report the header registers as they stand after this byte.
    always_comb begin
        logic [2:0] status_code;
        logic       emit_status;
        logic       emit_payload;

        n_phase       = r_phase;
        n_dest        = r_dest;
        n_source      = r_source;
        n_length      = r_length;
        n_left        = r_left;
        n_check       = r_check;
        n_status_sent = r_status_sent;
        status_code   = ST_BAD_HDR;
        emit_status   = 1'b0;
        emit_payload  = 1'b0;

        if (!r_status_sent) begin
            case (r_phase)
                PH_PREAMBLE: begin
                    n_dest   = '0;
                    n_source = '0;
                    n_length = '0;
                    n_left   = '0;
                    n_check  = '0;
                    n_phase  = (rx_byte == PREAMBLE_BYTE) ? PH_DEST : PH_BADPRE;
                    emit_status = last;
                end
                PH_DEST: begin
                    n_dest      = rx_byte;
                    n_check     = r_check ^ rx_byte;
                    n_phase     = PH_SOURCE;
                    emit_status = last;
                end
                PH_SOURCE: begin
                    n_source    = rx_byte;
                    n_check     = r_check ^ rx_byte;
                    n_phase     = PH_LENGTH;
                    emit_status = last;
                end
                PH_LENGTH: begin
                    n_length    = rx_byte;
                    n_left      = rx_byte;
                    n_check     = r_check ^ rx_byte;
                    n_phase     = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    emit_status = last;
                end
                PH_PAYLOAD: begin
                    if (last) begin
                        // Burst ended inside the payload: this byte is dropped.
                        status_code = ST_TRUNCATED;
                        emit_status = 1'b1;
                    end else begin
                        emit_payload = 1'b1;
                        n_check      = r_check ^ rx_byte;
                        n_left       = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = PH_CHECK;
                        end
                    end
                end
                PH_CHECK: begin
                    // Checksum is judged before the address filter.
                    if (rx_byte != r_check) begin
                        status_code = ST_CHECK_ERR;
                    end else if (r_dest != r_my_addr && r_dest != BROADCAST_ADDR) begin
                        status_code = ST_NOT_OURS;
                    end else begin
                        status_code = ST_ACCEPTED;
                    end
                    emit_status   = 1'b1;
                    n_status_sent = 1'b1;
                end
                PH_BADPRE: begin
                    // Header registers were cleared on the preamble byte.
                    emit_status = last;
                end
                default: begin
                    n_phase = PH_PREAMBLE;
                end
            endcase
        end

        // The end of a burst always rearms the parser.
        if (last) begin
            n_phase       = PH_PREAMBLE;
            n_status_sent = 1'b0;
        end

        has_result = emit_status | emit_payload;
        new_result = '0;
        if (emit_status) begin
            new_result.kind   = KIND_STATUS;
            new_result.status = status_code;
            new_result.dest   = n_dest;
            new_result.source = n_source;
            new_result.length = n_length;
        end else begin
            new_result.kind    = KIND_PAYLOAD;
            new_result.payload = emit_payload ? rx_byte : 8'd0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PREAMBLE;
            r_status_sent <= 1'b0;
            r_dest        <= '0;
            r_source      <= '0;
            r_length      <= '0;
            r_left        <= '0;
            r_check       <= '0;
            r_my_addr     <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_my_addr <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase       <= n_phase;
                r_status_sent <= n_status_sent;
                r_dest        <= n_dest;
                r_source      <= n_source;
                r_length      <= n_length;
                r_left        <= n_left;
                r_check       <= n_check;
            end
            if (!r_out_valid || out_pop) begin
                // No push can arrive while the skid register is occupied.
                r_out_valid  <= r_skid_valid | (in_accept & has_result);
                r_skid_valid <= 1'b0;
            end else if (in_accept && has_result) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            r_out <= r_skid_valid ? r_skid : new_result;
        end else if (in_accept && has_result) begin
            r_skid <= new_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.length, r_out.source, r_out.dest,
                            r_out.status, r_out.payload};

endmodule
